FILE: hw/rtl/ctsa_pkg.sv
// Shared widths, register indexes and the queued sample record of the
// three-frame CAN sample assembler. No dependencies.
package ctsa_pkg;

    localparam int ID_W       = 11;
    localparam int DATA_W     = 64;
    localparam int TAIL_W     = 40;
    localparam int SEQ_W      = 16;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_FIRST_ID,
        REG_SECOND_ID,
        REG_THIRD_ID
    } cfg_reg_t;

    localparam logic [IDX_W-1:0] WORD_FIRST  = 2'd0;
    localparam logic [IDX_W-1:0] WORD_SECOND = 2'd1;
    localparam logic [IDX_W-1:0] WORD_TAIL   = 2'd2;

    // One completed sample, handed from the front end to the word serializer.
    typedef struct packed {
        logic [DATA_W-1:0] word0;
        logic [DATA_W-1:0] word1;
        logic [TAIL_W-1:0] tail;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  incomplete;
    } sample_t;

endpackage

FILE: hw/rtl/ctsa_intf.sv
// Valid/ready channel interfaces of the sample assembler: frame input,
// word output and configuration write. Depends on ctsa_pkg.
interface ctsa_frame_if import ctsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] frame_data;

    modport source (output valid, frame_id, frame_data, input ready);
    modport sink   (input valid, frame_id, frame_data, output ready);
endinterface

interface ctsa_result_if import ctsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  word_index;
    logic [DATA_W-1:0] word_data;
    logic [SEQ_W-1:0]  seq_num;
    logic [SEQ_W-1:0]  incomplete_count;
    logic              last;

    modport source (output valid, word_index, word_data, seq_num, incomplete_count, last,
                    input ready);
    modport sink   (input valid, word_index, word_data, seq_num, incomplete_count, last,
                    output ready);
endinterface

interface ctsa_cfg_if import ctsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ctsa_front.sv
// Front end: configuration registers, frame classification, ordering
// state, counters and word capture. Depends on ctsa_pkg and ctsa_intf.
module ctsa_front import ctsa_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    ctsa_frame_if.sink           frame,
    ctsa_cfg_if.sink             cfg,
    input  logic                 q_ready,
    output logic                 q_push,
    output sample_t              q_entry
);

    typedef enum logic [1:0] {
        STG_IDLE,
        STG_ONE,
        STG_TWO
    } stage_t;

    stage_t            stage_reg, stage_next;
    logic              enable_reg;
    logic [ID_W-1:0]   first_id_reg, second_id_reg, third_id_reg;
    logic [DATA_W-1:0] word0_reg, word0_next;
    logic [DATA_W-1:0] word1_reg, word1_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [SEQ_W-1:0]  incomplete_reg, incomplete_next;

    logic              fire;
    logic              match1, match2, match3;

    // Stall only on queue space; non-completing frames could pass, but are
    // held with the rest while the queue is full.
    assign frame.ready = q_ready;
    assign cfg.ready   = 1'b1;

    assign fire   = frame.valid && frame.ready && enable_reg;
    assign match1 = frame.frame_id == first_id_reg;
    assign match2 = frame.frame_id == second_id_reg;
    assign match3 = frame.frame_id == third_id_reg;

    always_comb
    begin
        stage_next      = stage_reg;
        word0_next      = word0_reg;
        word1_next      = word1_reg;
        seq_next        = seq_reg;
        incomplete_next = incomplete_reg;
        q_push          = 1'b0;
        if (fire)
        begin
            if (match1)
            begin
                if (stage_reg != STG_IDLE)
                begin
                    incomplete_next = incomplete_reg + 1'b1;
                end
                word0_next = frame.frame_data;
                stage_next = STG_ONE;
            end
            else if (match2)
            begin
                if (stage_reg != STG_ONE)
                begin
                    incomplete_next = incomplete_reg + 1'b1;
                    stage_next      = STG_IDLE;
                end
                else
                begin
                    word1_next = frame.frame_data;
                    stage_next = STG_TWO;
                end
            end
            else if (match3)
            begin
                if (stage_reg != STG_TWO)
                begin
                    incomplete_next = incomplete_reg + 1'b1;
                end
                else
                begin
                    seq_next = seq_reg + 1'b1;
                    q_push   = 1'b1;
                end
                stage_next = STG_IDLE;
            end
        end
    end

    assign q_entry.word0      = word0_reg;
    assign q_entry.word1      = word1_reg;
    assign q_entry.tail       = frame.frame_data[TAIL_W-1:0];
    assign q_entry.seq        = seq_next;
    assign q_entry.incomplete = incomplete_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= STG_IDLE;
            enable_reg     <= 1'b0;
            first_id_reg   <= '0;
            second_id_reg  <= '0;
            third_id_reg   <= '0;
            seq_reg        <= '0;
            incomplete_reg <= '0;
        end
        else
        begin
            stage_reg      <= stage_next;
            seq_reg        <= seq_next;
            incomplete_reg <= incomplete_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_ENABLE:    enable_reg    <= cfg.data[0];
                    REG_FIRST_ID:  first_id_reg  <= cfg.data[ID_W-1:0];
                    REG_SECOND_ID: second_id_reg <= cfg.data[ID_W-1:0];
                    REG_THIRD_ID:  third_id_reg  <= cfg.data[ID_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Captured words need no reset: stage two is reached only after both are written.
    always_ff @(posedge clk)
    begin
        word0_reg <= word0_next;
        word1_reg <= word1_next;
    end

endmodule

FILE: hw/rtl/ctsa_queue.sv
// Small FIFO of completed samples between the front end and the word
// serializer. Depends on ctsa_pkg.
module ctsa_queue import ctsa_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sample_t push_entry,
    output logic    push_ready,
    input  logic    pop,
    output logic    pop_valid,
    output sample_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sample_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/ctsa_back.sv
// Word serializer: holds one sample and sends it as three 64-bit words.
// Depends on ctsa_pkg and ctsa_intf.
module ctsa_back import ctsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  sample_t     q_entry,
    output logic        q_pop,
    ctsa_result_if.source result
);

    sample_t          entry_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_fire;
    logic             is_last;

    assign is_last  = idx_reg == WORD_TAIL;
    assign out_fire = result.valid && result.ready;
    assign q_pop    = q_valid && (!busy_reg || (out_fire && is_last));

    assign result.valid            = busy_reg;
    assign result.word_index       = idx_reg;
    assign result.seq_num          = entry_reg.seq;
    assign result.incomplete_count = entry_reg.incomplete;
    assign result.last             = is_last;

    always_comb
    begin
        case (idx_reg)
            WORD_FIRST:  result.word_data = entry_reg.word0;
            WORD_SECOND: result.word_data = entry_reg.word1;
            default:     result.word_data = {{(DATA_W-TAIL_W){1'b0}}, entry_reg.tail};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= WORD_FIRST;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= WORD_FIRST;
            end
            else if (out_fire)
            begin
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                    idx_reg  <= WORD_FIRST;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            entry_reg <= q_entry;
        end
    end

endmodule

FILE: hw/rtl/can_three_frame_sample_assembler_top.sv
// Top level of the three-frame CAN sample assembler: front end, sample
// queue and word serializer. Depends on ctsa_pkg, ctsa_intf and submodules.
//
// Usage:
//   frame  - one received CAN frame per transfer (11-bit id, 8 data bytes).
//   cfg    - register writes: 0 enable, 1..3 identifiers of frames 1..3.
//            Always ready; write only while no sample is in flight.
//   result - three words per completed sample (index 0, 1, 2; last on 2).
// A frame is taken in the cycle it is offered whenever the sample queue
// has room, so frames may arrive back to back. The frame that completes a
// sample enters the queue at its transfer; word 0 is offered once it has
// passed the queue and been loaded into the serializer, and the words
// follow one per cycle while result is ready; the serializer sets the
// sustained rate. Other frames are taken but yield no words.
// If result stalls, the serializer holds its word and the queue fills; once
// it is full, frame.ready drops until a sample has been fully sent.
// Reset clears the ordering stage, both counters and the configuration
// (block disabled); no clearing pass is needed.
module can_three_frame_sample_assembler_top import ctsa_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ctsa_frame_if.sink    frame,
    ctsa_cfg_if.sink      cfg,
    ctsa_result_if.source result
);

    logic    push, push_ready, pop, pop_valid;
    sample_t push_entry, pop_entry;

    ctsa_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame),
        .cfg     (cfg),
        .q_ready (push_ready),
        .q_push  (push),
        .q_entry (push_entry)
    );

    ctsa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    ctsa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_entry (pop_entry),
        .q_pop   (pop),
        .result  (result)
    );

endmodule

FILE: verif/can_three_frame_sample_assembler_top_tb.sv
// Self-checking testbench of the three-frame CAN sample assembler: directed
// ordering cases, random frame traffic and output back-pressure.
// Depends on ctsa_pkg, the ctsa channel interfaces and the assembler RTL.
module can_three_frame_sample_assembler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctsa_pkg::*;

    typedef enum logic [1:0] {
        ASM_IDLE,
        ASM_HAVE_FIRST,
        ASM_HAVE_SECOND
    } asm_stage_t;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } can_frame_t;

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] data;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  incomplete;
        logic              last;
    } sample_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ctsa_frame_if  frame_ch();
    ctsa_cfg_if    cfg_ch();
    ctsa_result_if word_ch();

    can_three_frame_sample_assembler_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .cfg    (cfg_ch),
        .result (word_ch)
    );

    // Assembler state as the testbench sees it
    logic              cfg_enable = 1'b0;
    logic [ID_W-1:0]   cfg_first_id = '0;
    logic [ID_W-1:0]   cfg_second_id = '0;
    logic [ID_W-1:0]   cfg_third_id = '0;
    asm_stage_t        asm_stage = ASM_IDLE;
    logic [DATA_W-1:0] held_words [2];
    logic [SEQ_W-1:0]  samples_done = '0;
    logic [SEQ_W-1:0]  samples_broken = '0;
    sample_word_t      due_words [$];

    // Stimulus and pacing
    can_frame_t frame_q [$];
    int         frames_queued = 0;
    int         frames_taken = 0;
    bit         frame_taken_now = 1'b0;
    int         src_max_gap = 8;
    int         sink_max_stall = 8;
    int         gap_left = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         mismatches = 0;
    int         words_checked = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("timeout, %0d words still due", due_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void push_due(input logic [IDX_W-1:0] index,
                                     input logic [DATA_W-1:0] data);
        sample_word_t w;
        w.index = index;
        w.data = data;
        w.seq = samples_done;
        w.incomplete = samples_broken;
        w.last = (index == WORD_TAIL);
        due_words.push_back(w);
    endfunction

    function automatic void track_frame(input logic [ID_W-1:0] id,
                                        input logic [DATA_W-1:0] data);
        if (!cfg_enable)
            return;
        // identifier matches are prioritized: first over second over third
        if (id == cfg_first_id)
        begin
            if (asm_stage != ASM_IDLE)
                samples_broken++;
            held_words[0] = data;
            asm_stage = ASM_HAVE_FIRST;
        end
        else if (id == cfg_second_id)
        begin
            if (asm_stage != ASM_HAVE_FIRST)
            begin
                samples_broken++;
                asm_stage = ASM_IDLE;
            end
            else
            begin
                held_words[1] = data;
                asm_stage = ASM_HAVE_SECOND;
            end
        end
        else if (id == cfg_third_id)
        begin
            if (asm_stage != ASM_HAVE_SECOND)
                samples_broken++;
            else
            begin
                samples_done++;
                push_due(WORD_FIRST, held_words[0]);
                push_due(WORD_SECOND, held_words[1]);
                push_due(WORD_TAIL, {{(DATA_W-TAIL_W){1'b0}}, data[TAIL_W-1:0]});
            end
            asm_stage = ASM_IDLE;
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                            input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Frame driver: holds an offered frame until its transfer, then idles or
    // moves on to the next queued frame.
    initial
    begin
        can_frame_t f;
        frame_ch.valid = 1'b0;
        frame_ch.frame_id = '0;
        frame_ch.frame_data = '0;
        forever
        begin
            @(negedge clk);
            if (!frame_ch.valid || frame_taken_now)
            begin
                frame_taken_now = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    frame_ch.valid <= 1'b0;
                end
                else if (frame_q.size() > 0)
                begin
                    f = frame_q.pop_front();
                    frame_ch.valid <= 1'b1;
                    frame_ch.frame_id <= f.id;
                    frame_ch.frame_data <= f.data;
                end
                else
                    frame_ch.valid <= 1'b0;
            end
        end
    end

    // Word receiver; a long hold-off takes precedence over per-word stalls
    initial
    begin
        word_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                word_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                word_ch.ready <= 1'b0;
            end
            else
                word_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : sampler
        sample_word_t want;
        if (rst_n)
        begin
            if (word_ch.valid && word_ch.ready)
            begin
                if (due_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t ns: word with no sample due, index %0d data %h",
                                 $realtime, word_ch.word_index, word_ch.word_data);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (word_ch.word_index !== want.index)
                        report_mismatch("word_index", DATA_W'(want.index),
                                        DATA_W'(word_ch.word_index));
                    if (word_ch.word_data !== want.data)
                        report_mismatch("word_data", want.data, word_ch.word_data);
                    if (word_ch.seq_num !== want.seq)
                        report_mismatch("seq_num", DATA_W'(want.seq),
                                        DATA_W'(word_ch.seq_num));
                    if (word_ch.incomplete_count !== want.incomplete)
                        report_mismatch("incomplete_count", DATA_W'(want.incomplete),
                                        DATA_W'(word_ch.incomplete_count));
                    if (word_ch.last !== want.last)
                        report_mismatch("last", DATA_W'(want.last), DATA_W'(word_ch.last));
                    words_checked++;
                end
                stall_left = $urandom_range(0, sink_max_stall);
            end
            if (frame_ch.valid && frame_ch.ready)
            begin
                track_frame(frame_ch.frame_id, frame_ch.frame_data);
                frames_taken++;
                frame_taken_now = 1'b1;
                gap_left = $urandom_range(0, src_max_gap);
            end
        end
    end

    function automatic void queue_frame(input logic [ID_W-1:0] id,
                                        input logic [DATA_W-1:0] data);
        can_frame_t f;
        f.id = id;
        f.data = data;
        frame_q.push_back(f);
        frames_queued++;
    endfunction

    function automatic logic [DATA_W-1:0] rand_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= which;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (which)
            REG_ENABLE:    cfg_enable = value[0];
            REG_FIRST_ID:  cfg_first_id = value;
            REG_SECOND_ID: cfg_second_id = value;
            REG_THIRD_ID:  cfg_third_id = value;
            default:       ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every queued frame is taken and every due word is out; a
    // trailing wait covers a frame still in the front end that yields no word.
    task automatic settle();
        while (frames_taken != frames_queued || due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_ids(input logic [ID_W-1:0] id1, input logic [ID_W-1:0] id2,
                            input logic [ID_W-1:0] id3);
        write_reg(REG_FIRST_ID, id1);
        write_reg(REG_SECOND_ID, id2);
        write_reg(REG_THIRD_ID, id3);
    endtask

    task automatic random_ids(output logic [ID_W-1:0] id1, output logic [ID_W-1:0] id2,
                              output logic [ID_W-1:0] id3);
        // offsets below a third of the id space keep the three apart
        id1 = ID_W'($urandom_range(0, 2047));
        id2 = id1 + ID_W'($urandom_range(1, 682));
        id3 = id2 + ID_W'($urandom_range(1, 682));
    endtask

    task automatic test_disabled_after_reset();
        // all identifiers are zero after reset, but the block is off
        queue_frame('0, '1);
        settle();
    endtask

    task automatic test_ordering();
        load_ids(11'h000, 11'h7FF, 11'h2AA);
        write_reg(REG_ENABLE, 11'h001);
        // clean sample, tail bits above bit 39 must be dropped
        queue_frame(11'h000, '0);
        queue_frame(11'h7FF, '1);
        queue_frame(11'h2AA, '1);
        // restart on a repeated first frame, unrelated frame in between
        queue_frame(11'h000, rand_data());
        queue_frame(11'h000, rand_data());
        queue_frame(11'h7FF, rand_data());
        queue_frame(11'h155, rand_data());
        queue_frame(11'h2AA, rand_data());
        // second and third without a first
        queue_frame(11'h7FF, rand_data());
        queue_frame(11'h2AA, rand_data());
        // third right after first
        queue_frame(11'h000, rand_data());
        queue_frame(11'h2AA, rand_data());
        // duplicate second resets the stage, so the third is out of order
        queue_frame(11'h000, rand_data());
        queue_frame(11'h7FF, rand_data());
        queue_frame(11'h7FF, rand_data());
        queue_frame(11'h2AA, rand_data());
        settle();
    endtask

    task automatic test_disable_hold();
        queue_frame(cfg_first_id, rand_data());
        queue_frame(cfg_second_id, rand_data());
        settle();
        // enable takes bit 0 only
        write_reg(REG_ENABLE, 11'h7FE);
        queue_frame(cfg_third_id, rand_data());
        queue_frame(cfg_first_id, rand_data());
        settle();
        write_reg(REG_ENABLE, 11'h7FF);
        queue_frame(cfg_third_id, rand_data());
        settle();
    endtask

    task automatic test_equal_ids();
        load_ids(11'h3C3, 11'h3C3, 11'h3C3);
        queue_frame(11'h3C3, rand_data());
        queue_frame(11'h3C3, rand_data());
        settle();
        load_ids(11'h001, 11'h0F0, 11'h0F0);
        queue_frame(11'h001, rand_data());
        queue_frame(11'h0F0, rand_data());
        queue_frame(11'h0F0, rand_data());
        settle();
    endtask

    task automatic random_phase(input int n, input int max_gap, input int max_stall,
                                input logic [ID_W-1:0] id1, input logic [ID_W-1:0] id2,
                                input logic [ID_W-1:0] id3);
        int sent;
        settle();
        src_max_gap = max_gap;
        sink_max_stall = max_stall;
        load_ids(id1, id2, id3);
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                queue_frame(id1, rand_data());
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_frame(ID_W'($urandom_range(0, 2047)), rand_data());
                    sent++;
                end
                queue_frame(id2, rand_data());
                queue_frame(id3, rand_data());
                sent += 3;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       queue_frame(id1, rand_data());
                    1:       queue_frame(id2, rand_data());
                    2:       queue_frame(id3, rand_data());
                    default: queue_frame(ID_W'($urandom_range(0, 2047)), rand_data());
                endcase
                sent++;
            end
        end
        settle();
    endtask

    task automatic test_random_traffic();
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] c;
        random_ids(a, b, c);
        random_phase(70, 8, 8, a, b, c);
        random_phase(60, 0, 0, '0, '1, ID_W'($urandom_range(1, 2046)));
        random_ids(a, b, c);
        random_phase(65, 8, 0, a, b, c);
        random_ids(a, b, c);
        random_phase(65, 0, 8, a, b, c);
    endtask

    task automatic test_backpressure();
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] c;
        settle();
        random_ids(a, b, c);
        load_ids(a, b, c);
        src_max_gap = 0;
        sink_max_stall = 2;
        // output blocked long enough for the sample queue to fill
        hold_left = 300;
        repeat (8)
        begin
            queue_frame(a, rand_data());
            queue_frame(b, rand_data());
            queue_frame(c, rand_data());
        end
        settle();
        src_max_gap = 8;
        sink_max_stall = 8;
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ENABLE;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_disabled_after_reset();
        test_ordering();
        test_disable_hold();
        test_equal_ids();
        test_random_traffic();
        test_backpressure();

        settle();
        repeat (10) @(posedge clk);
        $display("%0d frames sent, %0d samples assembled, %0d broken sequences",
                 frames_taken, samples_done, samples_broken);
        $display("%0d words checked, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && due_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
